[rtl/core/gia_pkg.sv]
// Shared types and constants of the accelerator instance allocator.
// Used by gia_ctrl, gia_cell, gpu_instance_allocator and gia_checker.
// Depends on nothing.
`default_nettype none

package gia_pkg;

	localparam int MASK_BITS = 8;
	localparam int USAGE_W   = 12;
	localparam int PEND_W    = 10;
	localparam int CNT_W     = 4;
	localparam int COUNT_W   = 4;

	localparam logic [PEND_W-1:0]  PENDING_MAX  = 10'd1023;
	localparam logic [COUNT_W-1:0] COUNT_RESET  = 4'd8;

	typedef enum logic [1:0] {
		CMD_CLEAR = 2'd0,
		CMD_ADD   = 2'd1,
		CMD_SCHED = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_DONE      = 3'd0,
		ST_CONFIRMED = 3'd1,
		ST_FRAC      = 3'd2,
		ST_WHOLE     = 3'd3,
		ST_PRUNED    = 3'd4,
		ST_INVALID   = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_CLEAR,
		OP_ADD,
		OP_CONFIRM,
		OP_FRAC,
		OP_WHOLE
	} op_t;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_SCAN,
		PH_APPLY
	} phase_t;

	typedef struct packed {
		logic s_ready;
		logic scan_en;
		logic apply_en;
	} ctrl_t;

	typedef struct packed {
		logic             any_shared;
		logic             run_bad;
		logic [CNT_W-1:0] n_idle;
		logic [CNT_W-1:0] n_free;
	} scan_link_t;

	typedef struct packed {
		logic             taken;
		logic [CNT_W-1:0] got_idle;
		logic [CNT_W-1:0] got_pend;
	} apply_link_t;

	typedef struct packed {
		op_t                op;
		logic               use_shared;
		logic [USAGE_W-1:0] k;
		logic [USAGE_W-1:0] need_pend;
	} apply_ctl_t;

endpackage

`default_nettype wire

[rtl/core/gia_ctrl.sv]
// Phase sequencer of the allocator: idle, scan of all cells, apply and result.
// Depends on gia_pkg.
`default_nettype none

module gia_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_tvalid,
	input  wire logic          out_free,
	output gia_pkg::ctrl_t     ctl
);

	gia_pkg::phase_t phase_q;
	gia_pkg::phase_t phase_d;

	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			gia_pkg::PH_IDLE: begin
				if (s_tvalid) phase_d = gia_pkg::PH_SCAN;
			end
			gia_pkg::PH_SCAN: begin
				phase_d = gia_pkg::PH_APPLY;
			end
			gia_pkg::PH_APPLY: begin
				if (out_free) phase_d = s_tvalid ? gia_pkg::PH_SCAN : gia_pkg::PH_IDLE;
			end
			default: begin
				phase_d = gia_pkg::PH_IDLE;
			end
		endcase
	end

	always_comb begin
		ctl = '0;
		case (phase_q)
			gia_pkg::PH_IDLE: begin
				ctl.s_ready = 1'b1;
			end
			gia_pkg::PH_SCAN: begin
				ctl.scan_en = 1'b1;
			end
			gia_pkg::PH_APPLY: begin
				ctl.s_ready  = out_free;
				ctl.apply_en = out_free;
			end
			default: begin
				ctl = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= gia_pkg::PH_IDLE;
		end else begin
			phase_q <= phase_d;
		end
	end

endmodule

`default_nettype wire

[rtl/core/gia_cell.sv]
// One instance cell: holds the confirmed and pending share of one instance
// and passes scan totals and allocation progress on to the next cell.
// Depends on gia_pkg.
`default_nettype none

module gia_cell #(
	parameter int SHARE_ONE = 256,
	localparam int SHR_W = $clog2(SHARE_ONE + 1)
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   held,
	input  wire logic                   perm,
	input  wire logic [SHR_W-1:0]       share,
	input  wire gia_pkg::apply_ctl_t    ctl,
	input  wire logic                   apply_en,
	input  wire gia_pkg::scan_link_t    scan_in,
	output gia_pkg::scan_link_t         scan_out,
	input  wire gia_pkg::apply_link_t   link_in,
	output gia_pkg::apply_link_t        link_out,
	output logic                        grant_bit
);

	localparam int SUM_W = ((SHR_W > gia_pkg::PEND_W) ? SHR_W : gia_pkg::PEND_W) + 2;

	logic [SHR_W-1:0]          conf_q;
	logic [gia_pkg::PEND_W-1:0] pend_q;
	logic [SHR_W-1:0]          conf_d;
	logic [gia_pkg::PEND_W-1:0] pend_d;

	logic [SUM_W-1:0] conf_x;
	logic [SUM_W-1:0] pend_x;
	logic [SUM_W-1:0] share_x;
	logic [SUM_W-1:0] one_x;
	logic [SUM_W-1:0] pend_add;

	logic used;
	logic free;
	logic idle;
	logic pfree;
	logic shared_room;
	logic run_bad;
	logic cand;
	logic take_frac;
	logic take_idle;
	logic take_pend;

	assign conf_x   = SUM_W'(conf_q);
	assign pend_x   = SUM_W'(pend_q);
	assign share_x  = SUM_W'(share);
	assign one_x    = SUM_W'(SHARE_ONE);
	assign pend_add = pend_x + share_x;

	assign used        = (conf_q != '0) || (pend_q != '0);
	assign free        = perm && (conf_q == '0);
	assign idle        = free && (pend_q == '0);
	assign pfree       = free && (pend_q != '0);
	assign shared_room = perm && used && (conf_x + pend_x + share_x <= one_x);
	assign run_bad     = held && (conf_x + share_x > one_x);

	always_comb begin
		scan_out.any_shared = scan_in.any_shared | shared_room;
		scan_out.run_bad    = scan_in.run_bad | run_bad;
		scan_out.n_idle     = scan_in.n_idle + gia_pkg::CNT_W'(idle);
		scan_out.n_free     = scan_in.n_free + gia_pkg::CNT_W'(free);
	end

	assign cand      = ctl.use_shared ? shared_room : free;
	assign take_frac = (ctl.op == gia_pkg::OP_FRAC) && cand && !link_in.taken;
	assign take_idle = (ctl.op == gia_pkg::OP_WHOLE) && idle &&
		(gia_pkg::USAGE_W'(link_in.got_idle) < ctl.k);
	assign take_pend = (ctl.op == gia_pkg::OP_WHOLE) && pfree &&
		(gia_pkg::USAGE_W'(link_in.got_pend) < ctl.need_pend);

	always_comb begin
		link_out.taken    = link_in.taken | ((ctl.op == gia_pkg::OP_FRAC) && cand);
		link_out.got_idle = link_in.got_idle + gia_pkg::CNT_W'(take_idle);
		link_out.got_pend = link_in.got_pend + gia_pkg::CNT_W'(take_pend);
	end

	always_comb begin
		conf_d    = conf_q;
		pend_d    = pend_q;
		grant_bit = 1'b0;
		case (ctl.op)
			gia_pkg::OP_CLEAR: begin
				conf_d = '0;
				pend_d = '0;
			end
			gia_pkg::OP_ADD: begin
				grant_bit = held;
				if (held) begin
					pend_d = (pend_add > SUM_W'(gia_pkg::PENDING_MAX)) ?
						gia_pkg::PENDING_MAX : gia_pkg::PEND_W'(pend_add);
				end
			end
			gia_pkg::OP_CONFIRM: begin
				grant_bit = held;
				if (held) begin
					conf_d = SHR_W'(conf_x + share_x);
					pend_d = (pend_x > share_x) ? gia_pkg::PEND_W'(pend_x - share_x) : '0;
				end
			end
			gia_pkg::OP_FRAC: begin
				grant_bit = take_frac;
				if (take_frac) conf_d = SHR_W'(conf_x + share_x);
			end
			gia_pkg::OP_WHOLE: begin
				grant_bit = take_idle | take_pend;
				if (take_idle || take_pend) conf_d = SHR_W'(SHARE_ONE);
			end
			default: begin
				grant_bit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			conf_q <= '0;
			pend_q <= '0;
		end else if (apply_en) begin
			conf_q <= conf_d;
			pend_q <= pend_d;
		end
	end

endmodule

`default_nettype wire

[rtl/core/gpu_instance_allocator.sv]
// Top level of the accelerator instance allocator: stream ports, command
// decode, whole-multiple check and the row of instance cells.
// Depends on gia_pkg, gia_ctrl and gia_cell.
//
//   channel  direction  handshake            payload
//   s_       in         s_tvalid / s_tready  s_tdata, s_tuser (command)
//   m_       out        m_tvalid / m_tready  m_tdata, m_tuser (grant, status)
//   cfg_     in         cfg_valid/cfg_ready  cfg_data (instance count)
//
// Every command passes a scan over the cell row that totals free and shared
// instances, then an apply phase that updates the cells and loads the result
// register. A new transfer is taken in the apply phase, so the next command
// enters while the last one is applied. A full result register that is not
// taken holds the apply phase. Reset clears all shares and sets the instance
// count to eight; no clearing pass is needed.
`default_nettype none

module gpu_instance_allocator #(
	parameter int INSTANCES = 8,
	parameter int SHARE_ONE = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,  // usage[11:0], held_mask[19:12], permitted_mask[27:20]
	input  wire logic [2:0]  s_tuser,  // command[1:0], job_running[2]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,  // assigned_mask[7:0]
	output logic [3:0]       m_tuser,  // granted[0], status[3:1]
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [3:0]  cfg_data  // instance_count[3:0]
);

	localparam int SHR_W   = $clog2(SHARE_ONE + 1);
	localparam int RECIP_W = 33 - $clog2(SHARE_ONE);
	localparam int PROD_W  = gia_pkg::USAGE_W + RECIP_W;
	localparam longint unsigned RECIP_L =
		((64'd1 << 32) + longint'(SHARE_ONE) - 64'd1) / longint'(SHARE_ONE);
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);

	gia_pkg::ctrl_t ctl;
	logic           out_free;
	logic           accept;

	logic [gia_pkg::COUNT_W-1:0] count_q;

	gia_pkg::cmd_t                   cmd_q;
	logic [gia_pkg::USAGE_W-1:0]     usage_q;
	logic                            run_q;
	logic [gia_pkg::MASK_BITS-1:0]   held_q;
	logic [gia_pkg::MASK_BITS-1:0]   perm_q;

	logic [PROD_W-1:0]           prod;
	logic [gia_pkg::USAGE_W-1:0] k_q;
	logic                        exact_q;
	gia_pkg::scan_link_t         totals_q;

	gia_pkg::scan_link_t  scan_c [0:INSTANCES];
	gia_pkg::apply_link_t link_c [0:INSTANCES];
	logic [INSTANCES-1:0] grant_bits;
	logic [INSTANCES-1:0] held_b;
	logic [INSTANCES-1:0] perm_b;
	logic [gia_pkg::MASK_BITS-1:0] mask_d;

	logic               below_one;
	logic               invalid;
	logic [SHR_W-1:0]   share;
	gia_pkg::apply_ctl_t actl;
	logic               grant_d;
	gia_pkg::status_t   status_d;
	logic               mask_en;

	logic                          m_tvalid_q;
	logic                          grant_q;
	gia_pkg::status_t              status_q;
	logic [gia_pkg::MASK_BITS-1:0] mask_q;

	gia_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.out_free (out_free),
		.ctl      (ctl)
	);

	assign out_free  = !m_tvalid_q || m_tready;
	assign s_tready  = ctl.s_ready;
	assign accept    = s_tvalid && ctl.s_ready;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= gia_pkg::COUNT_RESET;
		end else if (cfg_valid) begin
			count_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= gia_pkg::cmd_t'(s_tuser[1:0]);
			run_q   <= s_tuser[2];
			usage_q <= s_tdata[11:0];
			held_q  <= s_tdata[19:12];
			perm_q  <= s_tdata[27:20];
		end
	end

	// The quotient by the instance size comes from a rounded-up reciprocal;
	// the low word of the product stays below the reciprocal exactly when
	// the usage is a whole multiple.
	assign prod = PROD_W'(usage_q) * PROD_W'(RECIP);

	always_ff @(posedge clk) begin
		if (ctl.scan_en) begin
			k_q      <= gia_pkg::USAGE_W'(prod[PROD_W-1:32]);
			exact_q  <= prod[31:0] < 32'(RECIP);
			totals_q <= scan_c[INSTANCES];
		end
	end

	assign below_one = {1'b0, usage_q} < (gia_pkg::USAGE_W + 1)'(SHARE_ONE);
	assign invalid   = (usage_q == '0) || (!below_one && !exact_q);
	assign share     = below_one ? SHR_W'(usage_q) : SHR_W'(SHARE_ONE);

	always_comb begin
		actl.op         = gia_pkg::OP_NONE;
		actl.use_shared = totals_q.any_shared;
		actl.k          = k_q;
		actl.need_pend  = (k_q > gia_pkg::USAGE_W'(totals_q.n_idle)) ?
			k_q - gia_pkg::USAGE_W'(totals_q.n_idle) : '0;
		grant_d  = 1'b0;
		status_d = gia_pkg::ST_DONE;
		mask_en  = 1'b0;
		case (cmd_q)
			gia_pkg::CMD_CLEAR: begin
				actl.op = gia_pkg::OP_CLEAR;
				grant_d = 1'b1;
			end
			gia_pkg::CMD_ADD: begin
				if (invalid) begin
					status_d = gia_pkg::ST_INVALID;
				end else begin
					actl.op = gia_pkg::OP_ADD;
					grant_d = 1'b1;
					mask_en = 1'b1;
				end
			end
			gia_pkg::CMD_SCHED: begin
				if (invalid) begin
					status_d = gia_pkg::ST_INVALID;
				end else if (run_q) begin
					if (totals_q.run_bad) begin
						status_d = gia_pkg::ST_PRUNED;
					end else begin
						actl.op  = gia_pkg::OP_CONFIRM;
						grant_d  = 1'b1;
						mask_en  = 1'b1;
						status_d = gia_pkg::ST_CONFIRMED;
					end
				end else if (below_one) begin
					actl.op  = gia_pkg::OP_FRAC;
					grant_d  = link_c[INSTANCES].taken;
					mask_en  = 1'b1;
					status_d = link_c[INSTANCES].taken ? gia_pkg::ST_FRAC : gia_pkg::ST_PRUNED;
				end else if (gia_pkg::USAGE_W'(totals_q.n_free) < k_q) begin
					status_d = gia_pkg::ST_PRUNED;
				end else begin
					actl.op  = gia_pkg::OP_WHOLE;
					grant_d  = 1'b1;
					mask_en  = 1'b1;
					status_d = gia_pkg::ST_WHOLE;
				end
			end
			default: begin
				actl.op = gia_pkg::OP_NONE;
			end
		endcase
	end

	assign scan_c[0] = '0;
	assign link_c[0] = '0;

	for (genvar g = 0; g < INSTANCES; g++) begin : g_cell
		if (g < gia_pkg::MASK_BITS) begin : g_live
			assign held_b[g] = held_q[g] && (count_q > gia_pkg::COUNT_W'(g));
			assign perm_b[g] = perm_q[g] && (count_q > gia_pkg::COUNT_W'(g));
		end else begin : g_absent
			assign held_b[g] = 1'b0;
			assign perm_b[g] = 1'b0;
		end

		gia_cell #(
			.SHARE_ONE (SHARE_ONE)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.held      (held_b[g]),
			.perm      (perm_b[g]),
			.share     (share),
			.ctl       (actl),
			.apply_en  (ctl.apply_en),
			.scan_in   (scan_c[g]),
			.scan_out  (scan_c[g+1]),
			.link_in   (link_c[g]),
			.link_out  (link_c[g+1]),
			.grant_bit (grant_bits[g])
		);
	end

	for (genvar b = 0; b < gia_pkg::MASK_BITS; b++) begin : g_mask
		if (b < INSTANCES) begin : g_bit
			assign mask_d[b] = grant_bits[b] && mask_en;
		end else begin : g_zero
			assign mask_d[b] = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (ctl.apply_en) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.apply_en) begin
			grant_q  <= grant_d;
			status_q <= status_d;
			mask_q   <= mask_d;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = mask_q;
	assign m_tuser  = {status_q, grant_q};

endmodule

`default_nettype wire

[rtl/core/gia_checker.sv]
// Port-level checks of the allocator and the bind that attaches them.
// Depends on gia_pkg and gpu_instance_allocator.
`default_nettype none

module gia_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       s_tvalid,
	input wire logic       s_tready,
	input wire logic       m_tvalid,
	input wire logic       m_tready,
	input wire logic [7:0] m_tdata,
	input wire logic [3:0] m_tuser
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("Result changed while stalled.");

	a_scan_gap: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("Input taken during the scan cycle.");

	a_refused_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata == 8'd0)
		else $error("Refused job carries instances.");

	a_grant_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[3:1] == gia_pkg::ST_CONFIRMED ||
			m_tuser[3:1] == gia_pkg::ST_FRAC || m_tuser[3:1] == gia_pkg::ST_WHOLE)
		|-> m_tuser[0])
		else $error("Successful status without a grant.");

	a_frac_single: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[3:1] == gia_pkg::ST_FRAC |-> $onehot(m_tdata))
		else $error("Fractional job placed on other than one instance.");

endmodule

bind gpu_instance_allocator gia_checker u_gia_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire
